// ===== design/iba_pkg.sv =====
// Shared types and constants of the IMU FIFO batch averager.
package iba_pkg;

  localparam int SUM_W = 32;
  localparam int AXES = 3;
  localparam int DEF_MAX_BATCH_WORDS = 512;

  localparam logic [1:0] CMD_ACCEL = 2'd1;
  localparam logic [1:0] CMD_GYRO  = 2'd2;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_OVF     = 2'd1;
  localparam logic [1:0] STATUS_MISSING = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_CHECK,
    ST_DSTART,
    ST_DWAIT,
    ST_FIN
  } iba_state_t;

  typedef struct packed {
    logic       in_ready;
    logic       acc_en;
    logic [1:0] acc_idx;
    logic       div_start;
    logic [2:0] div_idx;
    logic       q_load;
    logic       fin;
  } iba_ctrl_t;

endpackage

// ===== design/iba_div.sv =====
// Shared serial divider: signed 32-bit dividend by unsigned count, one bit a cycle.
module iba_div import iba_pkg::*; #(
  parameter int CNT_W = 10
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0]        divisor,
  output logic                    done,
  output logic signed [SUM_W-1:0] quotient
);

  localparam int STEP_W = $clog2(SUM_W);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SUM_W - 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [SUM_W-1:0]  q_r, q_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  dsr_r, dsr_nxt;
  logic              neg_r, neg_nxt;
  logic [CNT_W:0]    trial;
  logic              qbit;

  assign trial = {rem_r, q_r[SUM_W-1]};
  assign qbit  = (trial >= {1'b0, dsr_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    neg_nxt  = neg_r;
    if (start && !busy_r) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      q_nxt    = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      neg_nxt  = dividend[SUM_W-1];
    end else if (busy_r) begin
      // restoring step: remainder stays below the divisor
      rem_nxt  = qbit ? CNT_W'(trial - {1'b0, dsr_r}) : trial[CNT_W-1:0];
      q_nxt    = {q_r[SUM_W-2:0], qbit};
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    step_r <= step_nxt;
    q_r    <= q_nxt;
    rem_r  <= rem_nxt;
    dsr_r  <= dsr_nxt;
    neg_r  <= neg_nxt;
  end

  assign done     = done_r;
  assign quotient = neg_r ? (~q_r + 1'b1) : q_r;

endmodule

// ===== design/iba_accum.sv =====
// Batch sums, word counts and sticky overflow; the sums are updated through one shared adder.
module iba_accum import iba_pkg::*; #(
  parameter int MAX_BATCH_WORDS = DEF_MAX_BATCH_WORDS,
  parameter int CNT_W = 10
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  iba_ctrl_t               ctrl,
  input  logic                    is_gyro,
  input  logic signed [SUM_W-1:0] addend,
  output logic signed [SUM_W-1:0] accel_sum [AXES],
  output logic signed [SUM_W-1:0] gyro_sum [AXES],
  output logic [CNT_W-1:0]        accel_cnt,
  output logic [CNT_W-1:0]        gyro_cnt,
  output logic                    ovf
);

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BATCH_WORDS);

  logic signed [SUM_W-1:0] accel_r [AXES];
  logic signed [SUM_W-1:0] gyro_r [AXES];
  logic [CNT_W-1:0]        acnt_r, gcnt_r;
  logic                    ovf_r;
  logic signed [SUM_W-1:0] opnd, sum;
  logic                    sum_ovf;
  logic [CNT_W-1:0]        cnt_sel;
  logic                    cnt_full;

  assign opnd     = is_gyro ? gyro_r[ctrl.acc_idx] : accel_r[ctrl.acc_idx];
  assign sum      = opnd + addend;
  assign sum_ovf  = (opnd[SUM_W-1] == addend[SUM_W-1]) && (sum[SUM_W-1] != opnd[SUM_W-1]);
  assign cnt_sel  = is_gyro ? gcnt_r : acnt_r;
  assign cnt_full = (cnt_sel >= CNT_MAX);

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.fin) begin
      for (int i = 0; i < AXES; i++) begin
        accel_r[i] <= '0;
        gyro_r[i]  <= '0;
      end
      acnt_r <= '0;
      gcnt_r <= '0;
      ovf_r  <= 1'b0;
    end else if (ctrl.acc_en) begin
      if (is_gyro) gyro_r[ctrl.acc_idx] <= sum;
      else         accel_r[ctrl.acc_idx] <= sum;
      if (sum_ovf) ovf_r <= 1'b1;
      // count once per word, on the first axis
      if (ctrl.acc_idx == '0) begin
        if (cnt_full)     ovf_r  <= 1'b1;
        else if (is_gyro) gcnt_r <= gcnt_r + 1'b1;
        else              acnt_r <= acnt_r + 1'b1;
      end
    end
  end

  assign accel_sum = accel_r;
  assign gyro_sum  = gyro_r;
  assign accel_cnt = acnt_r;
  assign gyro_cnt  = gcnt_r;
  assign ovf       = ovf_r;

endmodule

// ===== design/iba_seq.sv =====
// Sequencer: axis accumulation steps, end-of-batch check, six divisions and the final hand-off.
module iba_seq import iba_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      word_used,
  input  logic      last_word,
  input  logic      batch_bad,
  input  logic      div_done,
  input  logic      out_free,
  output iba_ctrl_t ctrl
);

  localparam logic [1:0] AXIS_LAST = 2'(AXES - 1);
  localparam logic [2:0] DIV_LAST  = 3'(2 * AXES - 1);

  iba_state_t state_r, state_nxt;
  logic [1:0] acc_idx_r, acc_idx_nxt;
  logic [2:0] div_idx_r, div_idx_nxt;

  always_comb begin
    state_nxt   = state_r;
    acc_idx_nxt = acc_idx_r;
    div_idx_nxt = div_idx_r;
    unique case (state_r)
      ST_IDLE: begin
        acc_idx_nxt = '0;
        if (in_valid) state_nxt = ST_ACC;
      end
      ST_ACC: begin
        acc_idx_nxt = acc_idx_r + 1'b1;
        if (!word_used || acc_idx_r == AXIS_LAST) begin
          state_nxt = last_word ? ST_CHECK : ST_IDLE;
        end
      end
      ST_CHECK: begin
        div_idx_nxt = '0;
        state_nxt   = batch_bad ? ST_FIN : ST_DSTART;
      end
      ST_DSTART: state_nxt = ST_DWAIT;
      ST_DWAIT: begin
        if (div_done) begin
          div_idx_nxt = div_idx_r + 1'b1;
          state_nxt   = (div_idx_r == DIV_LAST) ? ST_FIN : ST_DSTART;
        end
      end
      ST_FIN: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl           = '0;
    ctrl.acc_idx   = acc_idx_r;
    ctrl.div_idx   = div_idx_r;
    ctrl.in_ready  = (state_r == ST_IDLE);
    ctrl.acc_en    = (state_r == ST_ACC) && word_used;
    ctrl.div_start = (state_r == ST_DSTART);
    ctrl.q_load    = (state_r == ST_DWAIT) && div_done;
    ctrl.fin       = (state_r == ST_FIN) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      acc_idx_r <= '0;
      div_idx_r <= '0;
    end else begin
      state_r   <= state_nxt;
      acc_idx_r <= acc_idx_nxt;
      div_idx_r <= div_idx_nxt;
    end
  end

endmodule

// ===== design/imu_fifo_batch_averager.sv =====
// Top level of the IMU FIFO batch averager: input capture, result buffer and output register.
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+--------------------------------------------------
//  in_     | in        | in_valid/in_stall | command, axis_x/y/z, last
//  out_    | out       | out_valid/out_stall | status, avg_accel_x/y/z, avg_gyro_x/y/z
//
// Steps: an ignored word is accepted and dropped; an accel or gyro word is accepted, then
//   adds one axis at a time through the single shared adder.
// A word marked last then takes a check step and, on success, six divisions in turn
//   in the shared bit-serial divider (start, quotient bits, done), then a hand-off of
//   the item to the output register.
// Reset (rst_n low, synchronous) clears the sequencer, sums, counts and the flag.
// out_stall only holds the output register; the block keeps taking items and only
//   waits at the end of a batch if the previous result is still not taken.
module imu_fifo_batch_averager import iba_pkg::*; #(
  parameter int MAX_BATCH_WORDS = DEF_MAX_BATCH_WORDS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_command,
  input  logic signed [SUM_W-1:0] in_axis_x,
  input  logic signed [SUM_W-1:0] in_axis_y,
  input  logic signed [SUM_W-1:0] in_axis_z,
  input  logic                    in_last,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              out_status,
  output logic signed [SUM_W-1:0] out_avg_accel_x,
  output logic signed [SUM_W-1:0] out_avg_accel_y,
  output logic signed [SUM_W-1:0] out_avg_accel_z,
  output logic signed [SUM_W-1:0] out_avg_gyro_x,
  output logic signed [SUM_W-1:0] out_avg_gyro_y,
  output logic signed [SUM_W-1:0] out_avg_gyro_z
);

  // counts must hold the bound itself
  localparam int CNT_W = $clog2(MAX_BATCH_WORDS + 1);

  iba_ctrl_t ctrl;

  // captured item
  logic [1:0]              cmd_r;
  logic signed [SUM_W-1:0] axis_r [AXES];
  logic                    last_r;
  logic                    in_acc;

  logic signed [SUM_W-1:0] accel_sum [AXES];
  logic signed [SUM_W-1:0] gyro_sum [AXES];
  logic [CNT_W-1:0]        accel_cnt, gyro_cnt;
  logic                    ovf;
  logic                    missing;
  logic                    is_gyro, word_used;

  logic signed [SUM_W-1:0] div_dividend, div_quot;
  logic [CNT_W-1:0]        div_divisor;
  logic                    div_done;
  logic                    div_gyro;
  logic [1:0]              div_axis;

  // quotients of the current batch, then the output register
  logic signed [SUM_W-1:0] quot_r [2*AXES];
  logic                    out_valid_r;
  logic [1:0]              out_status_r;
  logic signed [SUM_W-1:0] out_avg_r [2*AXES];
  logic                    out_free;
  logic [1:0]              status;

  assign in_acc    = in_valid && ctrl.in_ready;
  assign in_stall  = !ctrl.in_ready;
  assign is_gyro   = (cmd_r == CMD_GYRO);
  assign word_used = (cmd_r == CMD_ACCEL) || (cmd_r == CMD_GYRO);
  assign missing   = (accel_cnt == '0) || (gyro_cnt == '0);
  assign out_free  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r     <= in_command;
      axis_r[0] <= in_axis_x;
      axis_r[1] <= in_axis_y;
      axis_r[2] <= in_axis_z;
      last_r    <= in_last;
    end
  end

  iba_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .word_used (word_used),
    .last_word (last_r),
    .batch_bad (ovf || missing),
    .div_done  (div_done),
    .out_free  (out_free),
    .ctrl      (ctrl)
  );

  iba_accum #(
    .MAX_BATCH_WORDS (MAX_BATCH_WORDS),
    .CNT_W           (CNT_W)
  ) u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .is_gyro   (is_gyro),
    .addend    (axis_r[ctrl.acc_idx]),
    .accel_sum (accel_sum),
    .gyro_sum  (gyro_sum),
    .accel_cnt (accel_cnt),
    .gyro_cnt  (gyro_cnt),
    .ovf       (ovf)
  );

  // divisions run accel x, y, z then gyro x, y, z
  assign div_gyro     = (ctrl.div_idx >= 3'(AXES));
  assign div_axis     = div_gyro ? 2'(ctrl.div_idx - 3'(AXES)) : ctrl.div_idx[1:0];
  assign div_dividend = div_gyro ? gyro_sum[div_axis] : accel_sum[div_axis];
  assign div_divisor  = div_gyro ? gyro_cnt : accel_cnt;

  iba_div #(
    .CNT_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctrl.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_ff @(posedge clk) begin
    if (ctrl.q_load) quot_r[ctrl.div_idx] <= div_quot;
  end

  // overflow wins over a missing word kind
  always_comb begin
    priority if (ovf) status = STATUS_OVF;
    else if (missing) status = STATUS_MISSING;
    else              status = STATUS_OK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.fin) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.fin) begin
      out_status_r <= status;
      for (int i = 0; i < 2*AXES; i++) begin
        out_avg_r[i] <= (status == STATUS_OK) ? quot_r[i] : '0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_avg_accel_x = out_avg_r[0];
  assign out_avg_accel_y = out_avg_r[1];
  assign out_avg_accel_z = out_avg_r[2];
  assign out_avg_gyro_x  = out_avg_r[3];
  assign out_avg_gyro_y  = out_avg_r[4];
  assign out_avg_gyro_z  = out_avg_r[5];

endmodule

// ===== design/iba_checker.sv =====
// Port-level checks of the IMU FIFO batch averager, bound to the top level.
module iba_checker import iba_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [1:0]        out_status,
  input logic [SUM_W-1:0]  out_avg_accel_x,
  input logic [SUM_W-1:0]  out_avg_accel_y,
  input logic [SUM_W-1:0]  out_avg_accel_z,
  input logic [SUM_W-1:0]  out_avg_gyro_x,
  input logic [SUM_W-1:0]  out_avg_gyro_y,
  input logic [SUM_W-1:0]  out_avg_gyro_z
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_avg_gyro_z))
    else $error("stalled result changed");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STATUS_OK |->
      out_avg_accel_x == '0 && out_avg_accel_y == '0 && out_avg_accel_z == '0 &&
      out_avg_gyro_x == '0 && out_avg_gyro_y == '0 && out_avg_gyro_z == '0)
    else $error("failed batch carries averages");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == STATUS_OK || out_status == STATUS_OVF ||
                  out_status == STATUS_MISSING)
    else $error("unknown status code");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("item taken while previous one in progress");

endmodule

bind imu_fifo_batch_averager iba_checker u_iba_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_status      (out_status),
  .out_avg_accel_x (out_avg_accel_x),
  .out_avg_accel_y (out_avg_accel_y),
  .out_avg_accel_z (out_avg_accel_z),
  .out_avg_gyro_x  (out_avg_gyro_x),
  .out_avg_gyro_y  (out_avg_gyro_y),
  .out_avg_gyro_z  (out_avg_gyro_z)
);
